// ===== hw/rtl/owpu_pkg.sv =====
// Package: shared constants, codes and payload types of the OLED window upload block.
`timescale 1ns / 1ps
package owpu_pkg;

  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int STORE_BYTES = 1024;

  localparam int ROW_BYTES   = COLUMNS / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int IDX_W       = 11;
  localparam int ROWS_PER_PAGE = 8;

  localparam logic [7:0] OP_COL_ADDR  = 8'h21;
  localparam logic [7:0] OP_PAGE_ADDR = 8'h22;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_START   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CMDS,
    ST_GATHER
  } state_t;

  typedef enum logic [2:0] {
    SLOT_COL_OP,
    SLOT_COL_START,
    SLOT_COL_END,
    SLOT_PAGE_OP,
    SLOT_PAGE_START,
    SLOT_PAGE_END
  } slot_t;

  typedef struct packed {
    cmd_t       command;
    logic [9:0] fb_address;
    logic [7:0] fb_data;
    logic [6:0] col_start;
    logic [6:0] col_end;
    logic [5:0] row_start;
    logic [5:0] row_end;
  } owpu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic       window_done;
  } owpu_out_t;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } gather_stat_t;

endpackage

// ===== hw/rtl/owpu_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module owpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/owpu_gather.sv =====
// Bit-serial column gather: reads eight stored rows and shifts one pixel bit in per cycle.
`timescale 1ns / 1ps
module owpu_gather
  import owpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [2:0]        page,
  input  logic [6:0]        column,
  input  logic [7:0]        rdata,
  output logic [ADDR_W-1:0] addr,
  output gather_stat_t      stat
);

  logic             active_r, active_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [5:0]       row;
  logic [IDX_W-1:0] idx;
  logic             in_panel;
  logic             bit_in;

  // A column or page outside the panel reads as zero in every row.
  assign in_panel = ({1'b0, column} < 8'(COLUMNS)) && ({1'b0, page} < 4'(PAGES));
  assign row      = {page, cnt_r[2:0]};
  assign idx      = IDX_W'(row) * IDX_W'(ROW_BYTES) + IDX_W'(column[6:3]);
  assign addr     = idx[ADDR_W-1:0];
  assign bit_in   = rdata[~column[2:0]] & vld_r;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    vld_nxt    = vld_r;
    acc_nxt    = acc_r;
    stat.done  = 1'b0;
    stat.data  = {bit_in, acc_r[7:1]};
    if (go) begin
      active_nxt = 1'b1;
      cnt_nxt    = 4'd0;
    end else if (active_r) begin
      // Read data arrives in the cycle after its address, so the bit of row j lands at count j+1.
      vld_nxt = in_panel && (idx < IDX_W'(STORE_BYTES));
      if (cnt_r != 4'd0) begin
        acc_nxt = {bit_in, acc_r[7:1]};
      end
      if (cnt_r == 4'(ROWS_PER_PAGE)) begin
        stat.done  = 1'b1;
        active_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= 4'd0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
    vld_r <= vld_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// ===== hw/rtl/oled_window_page_upload.sv =====
// Top level: framebuffer store, command sequencer and window upload of a page-organized OLED.
// Usage: a request is taken at a rising edge with start high and busy low; in_req carries
// the command and its fields. Results appear on out_res for one cycle with out_strobe high
// and are always taken, since the receiver cannot stall.
// A write request stores one byte at its accepting edge and leaves busy low.
// A start request sets busy high and strobes the six command bytes one per cycle, the sixth
// flagged last; the next request may already be taken in the cycle in which the sixth is
// strobed.
// A clear request sends the same six command bytes for a full-screen window, then runs a
// clearing pass over all STORE_BYTES (1024) bytes of the store with busy high.
// An advance request with an open window reads eight stored rows one per cycle from the
// single RAM port and shifts in one pixel bit per cycle, with busy high; the data byte is
// strobed in the cycle in which busy is low again, when the next request may already be
// taken. So no new data byte is taken before the serial row gather of the last one is done.
// An advance with no open window causes no result and leaves busy low.
// After reset the block runs the clearing pass over all 1024 bytes, busy high, then goes idle
// with no window open.
`timescale 1ns / 1ps
module oled_window_page_upload
  import owpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  owpu_in_t  in_req,
  output logic      out_strobe,
  output owpu_out_t out_res
);

  state_t            state_r, state_nxt;
  slot_t             slot_r, slot_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic              clear_pend_r, clear_pend_nxt;
  logic [2:0]        cur_page_r, cur_page_nxt;
  logic [6:0]        cur_col_r, cur_col_nxt;
  logic [6:0]        win_cs_r, win_cs_nxt;
  logic [6:0]        win_ce_r, win_ce_nxt;
  logic [2:0]        win_pe_r, win_pe_nxt;
  logic              active_r, active_nxt;
  logic              strobe_r, strobe_nxt;
  owpu_out_t         out_r, out_nxt;

  logic              accept;
  logic              go;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [ADDR_W-1:0] g_addr;
  gather_stat_t      g_stat;
  logic              sweep_end;
  logic              wr_ok;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign go        = accept && (in_req.command == CMD_ADVANCE) && active_r;
  assign sweep_end = (sweep_r == ADDR_W'(STORE_BYTES - 1));
  assign wr_ok     = ({1'b0, in_req.fb_address} < IDX_W'(STORE_BYTES));

  owpu_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  owpu_gather u_gather (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .page  (cur_page_r),
    .column(cur_col_r),
    .rdata (ram_rdata),
    .addr  (g_addr),
    .stat  (g_stat)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.command == CMD_START || in_req.command == CMD_CLEAR) begin
            state_nxt = ST_CMDS;
          end else if (go) begin
            state_nxt = ST_GATHER;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CMDS: begin
        if (slot_r == SLOT_PAGE_END) begin
          state_nxt = clear_pend_r ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_GATHER: begin
        if (g_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, store port and results.
  always_comb begin
    slot_nxt       = slot_r;
    sweep_nxt      = sweep_r;
    clear_pend_nxt = clear_pend_r;
    cur_page_nxt   = cur_page_r;
    cur_col_nxt    = cur_col_r;
    win_cs_nxt     = win_cs_r;
    win_ce_nxt     = win_ce_r;
    win_pe_nxt     = win_pe_r;
    active_nxt     = active_r;
    strobe_nxt     = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_addr       = in_req.fb_address[ADDR_W-1:0];
    ram_wdata      = in_req.fb_data;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req.command)
            CMD_WRITE: begin
              ram_we = wr_ok;
            end
            CMD_START: begin
              slot_nxt     = SLOT_COL_OP;
              win_cs_nxt   = in_req.col_start;
              win_ce_nxt   = in_req.col_end;
              cur_col_nxt  = in_req.col_start;
              cur_page_nxt = in_req.row_start[5:3];
              win_pe_nxt   = in_req.row_end[5:3];
              active_nxt   = (in_req.col_start <= in_req.col_end) &&
                             (in_req.row_start[5:3] <= in_req.row_end[5:3]);
            end
            CMD_CLEAR: begin
              slot_nxt       = SLOT_COL_OP;
              clear_pend_nxt = 1'b1;
              win_cs_nxt     = 7'd0;
              win_ce_nxt     = 7'(COLUMNS - 1);
              cur_col_nxt    = 7'd0;
              cur_page_nxt   = 3'd0;
              win_pe_nxt     = 3'(PAGES - 1);
              active_nxt     = 1'b1;
            end
            CMD_ADVANCE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_r;
        ram_wdata = 8'd0;
        if (sweep_end) begin
          sweep_nxt      = '0;
          clear_pend_nxt = 1'b0;
        end else begin
          sweep_nxt = sweep_r + ADDR_W'(1);
        end
      end
      ST_CMDS: begin
        strobe_nxt          = 1'b1;
        out_nxt.is_data     = 1'b0;
        out_nxt.window_done = 1'b0;
        out_nxt.last        = (slot_r == SLOT_PAGE_END);
        slot_nxt            = (slot_r == SLOT_PAGE_END) ? SLOT_COL_OP :
                              slot_t'(slot_r + 3'd1);
        unique case (slot_r)
          SLOT_COL_OP:     out_nxt.out_byte = OP_COL_ADDR;
          SLOT_COL_START:  out_nxt.out_byte = {1'b0, win_cs_r};
          SLOT_COL_END:    out_nxt.out_byte = {1'b0, win_ce_r};
          SLOT_PAGE_OP:    out_nxt.out_byte = OP_PAGE_ADDR;
          SLOT_PAGE_START: out_nxt.out_byte = {5'd0, cur_page_r};
          SLOT_PAGE_END:   out_nxt.out_byte = {5'd0, win_pe_r};
          default:         out_nxt.out_byte = 8'd0;
        endcase
      end
      ST_GATHER: begin
        ram_addr = g_addr;
        if (g_stat.done) begin
          strobe_nxt          = 1'b1;
          out_nxt.out_byte    = g_stat.data;
          out_nxt.is_data     = 1'b1;
          out_nxt.last        = 1'b1;
          out_nxt.window_done = 1'b0;
          // Walk columns within a page, then step to the next page.
          if (cur_col_r == win_ce_r) begin
            cur_col_nxt = win_cs_r;
            if (cur_page_r == win_pe_r) begin
              active_nxt          = 1'b0;
              out_nxt.window_done = 1'b1;
            end else begin
              cur_page_nxt = cur_page_r + 3'd1;
            end
          end else begin
            cur_col_nxt = cur_col_r + 7'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      slot_r       <= SLOT_COL_OP;
      sweep_r      <= '0;
      clear_pend_r <= 1'b0;
      cur_page_r   <= 3'd0;
      cur_col_r    <= 7'd0;
      win_cs_r     <= 7'd0;
      win_ce_r     <= 7'd0;
      win_pe_r     <= 3'd0;
      active_r     <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      sweep_r      <= sweep_nxt;
      clear_pend_r <= clear_pend_nxt;
      cur_page_r   <= cur_page_nxt;
      cur_col_r    <= cur_col_nxt;
      win_cs_r     <= win_cs_nxt;
      win_ce_r     <= win_ce_nxt;
      win_pe_r     <= win_pe_nxt;
      active_r     <= active_nxt;
      strobe_r     <= strobe_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = out_r;

endmodule
